// ===== design/rtc_pkg.sv =====
// Shared types and constants for the real-time clock and calendar.
// Holds the calendar state word, request codes and field limits.
// No dependencies.
package rtc_pkg;

  localparam logic [3:0]  TICKS_PER_SECOND = 4'd15;
  localparam logic [5:0]  SEC_MAX          = 6'd59;
  localparam logic [5:0]  MIN_MAX          = 6'd59;
  localparam logic [4:0]  HOUR_MAX         = 5'd23;
  localparam logic [3:0]  MONTH_MAX        = 4'd12;
  localparam logic [13:0] YEAR_MAX         = 14'd9999;
  localparam logic [6:0]  YEAR_REM_MAX     = 7'd99;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_ADJUST = 1'b1;

  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  localparam logic [2:0] SEL_NONE   = 3'd0;
  localparam logic [2:0] SEL_SECOND = 3'd1;
  localparam logic [2:0] SEL_MINUTE = 3'd2;
  localparam logic [2:0] SEL_HOUR   = 3'd3;
  localparam logic [2:0] SEL_DAY    = 3'd4;
  localparam logic [2:0] SEL_MONTH  = 3'd5;
  localparam logic [2:0] SEL_YEAR   = 3'd6;

  localparam logic [1:0] CFG_ALARM_ENABLE = 2'd0;
  localparam logic [1:0] CFG_ALARM_HOUR   = 2'd1;
  localparam logic [1:0] CFG_ALARM_MINUTE = 2'd2;
  localparam logic [1:0] CFG_ALARM_SECOND = 2'd3;

  // The year is also kept as year mod 100 and (year / 100) mod 4, so the
  // leap-year rule needs no division.
  typedef struct packed {
    logic [3:0]  tick_count;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  year_rem;
    logic [1:0]  century_mod4;
  } cal_state_t;

  localparam cal_state_t CAL_RESET = '{
    tick_count:   4'd0,
    second:       6'd55,
    minute:       6'd59,
    hour:         5'd23,
    day:          5'd31,
    month:        4'd12,
    year:         14'd1999,
    year_rem:     7'd99,
    century_mod4: 2'd3
  };

endpackage

// ===== design/rtc_calendar_with_alarm.sv =====
// Top level of the real-time clock and calendar with alarm compare.
// Holds the calendar state, alarm registers and the result register.
// Depends on rtc_pkg and rtc_next.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid / req_ready | req_type, field_select, direction
//   rsp     | out       | rsp_valid / rsp_ready | second_now .. year_now, alarm_match
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each request word is applied to the state in the cycle it is accepted and its result
// word is registered, visible next cycle; one word per cycle while rsp_ready is high.
// req_ready is high whenever the result register is empty or being read out.
// cfg_ready is always high. Reset loads 23:59:55 on day 31, month 12, year 1999,
// clears the prescaler and alarm registers, and empties the result register.
module rtc_calendar_with_alarm import rtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic [2:0]  field_select,
  input  logic        direction,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [5:0]  second_now,
  output logic [5:0]  minute_now,
  output logic [4:0]  hour_now,
  output logic [4:0]  day_now,
  output logic [3:0]  month_now,
  output logic [13:0] year_now,
  output logic        alarm_match,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  cal_state_t cal;
  cal_state_t cal_next;
  logic       alarm_enable;
  logic [4:0] alarm_hour;
  logic [5:0] alarm_minute;
  logic [5:0] alarm_second;
  logic       req_fire;
  logic       match_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  rtc_next u_next (
    .cur          (cal),
    .req_type     (req_type),
    .field_select (field_select),
    .direction    (direction),
    .nxt          (cal_next)
  );

  assign match_next = alarm_enable && cal_next.hour == alarm_hour
                      && cal_next.minute == alarm_minute
                      && cal_next.second == alarm_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= CAL_RESET;
    end else if (req_fire) begin
      cal <= cal_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_enable <= 1'b0;
      alarm_hour   <= 5'd0;
      alarm_minute <= 6'd0;
      alarm_second <= 6'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALARM_ENABLE: alarm_enable <= cfg_data[0];
        CFG_ALARM_HOUR:   alarm_hour   <= cfg_data[4:0];
        CFG_ALARM_MINUTE: alarm_minute <= cfg_data;
        CFG_ALARM_SECOND: alarm_second <= cfg_data;
        default: alarm_enable <= alarm_enable;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      second_now  <= cal_next.second;
      minute_now  <= cal_next.minute;
      hour_now    <= cal_next.hour;
      day_now     <= cal_next.day;
      month_now   <= cal_next.month;
      year_now    <= cal_next.year;
      alarm_match <= match_next;
    end
  end

`ifndef SYNTHESIS
  a_tick_below_limit: assert property (@(posedge clk) disable iff (rst)
    cal.tick_count < TICKS_PER_SECOND)
    else $error("prescaler reached its limit");

  a_time_in_range: assert property (@(posedge clk) disable iff (rst)
    cal.hour <= HOUR_MAX && cal.minute <= MIN_MAX && cal.second <= SEC_MAX)
    else $error("time field out of range");

  a_year_split: assert property (@(posedge clk) disable iff (rst)
    cal.year <= YEAR_MAX && cal.year_rem <= YEAR_REM_MAX
    && cal.year[1:0] == cal.year_rem[1:0])
    else $error("year tracking registers disagree");

  a_adjust_keeps_prescaler: assert property (@(posedge clk) disable iff (rst)
    req_fire && req_type == REQ_ADJUST |=> $stable(cal.tick_count))
    else $error("adjust changed the prescaler");

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> rsp_valid)
    else $error("accepted request produced no result");
`endif

endmodule

// ===== design/rtc_next.sv =====
// Next-state logic of the clock and calendar for one request word.
// Handles ticks with second, minute, hour, day, month and year rollover, and field adjusts.
// Depends on rtc_pkg.
module rtc_next import rtc_pkg::*; (
  input  cal_state_t cur,
  input  logic       req_type,
  input  logic [2:0] field_select,
  input  logic       direction,
  output cal_state_t nxt
);

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Add or subtract one; going below zero or above the limit gives zero.
  function automatic logic [5:0] bump(input logic [5:0] v, input logic down,
                                      input logic [5:0] lim);
    logic [6:0] inc;
    logic [5:0] dec;
    logic [5:0] res;
    inc = {1'b0, v} + 7'd1;
    dec = v - 6'd1;
    if (down) begin
      res = (v == 6'd0 || dec > lim) ? 6'd0 : dec;
    end else begin
      res = (inc > {1'b0, lim}) ? 6'd0 : inc[5:0];
    end
    return res;
  endfunction

  logic       leap;
  logic [4:0] mlen;
  logic [3:0] tick_inc;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [5:0] day_inc;
  logic [4:0] month_inc;
  logic [5:0] hour_adj;
  logic [5:0] day_adj;
  logic [5:0] month_adj;

  assign leap = (cur.year_rem == 7'd0) ? (cur.century_mod4 == 2'd0)
                                       : (cur.year_rem[1:0] == 2'd0);
  assign mlen = month_length(cur.month, leap);

  assign hour_adj  = bump({1'b0, cur.hour}, direction, {1'b0, HOUR_MAX});
  assign day_adj   = bump({1'b0, cur.day}, direction, {1'b0, mlen});
  assign month_adj = bump({2'b0, cur.month}, direction, {2'b0, MONTH_MAX});

  always_comb begin
    nxt       = cur;
    tick_inc  = cur.tick_count + 4'd1;
    sec_inc   = {1'b0, cur.second} + 7'd1;
    min_inc   = {1'b0, cur.minute};
    hour_inc  = {1'b0, cur.hour};
    day_inc   = {1'b0, cur.day} + 6'd1;
    month_inc = {1'b0, cur.month} + 5'd1;

    if (req_type == REQ_TICK) begin
      nxt.tick_count = tick_inc;
      if (tick_inc >= TICKS_PER_SECOND) begin
        nxt.tick_count = 4'd0;
        if (sec_inc > {1'b0, SEC_MAX}) begin
          sec_inc = 7'd0;
          min_inc = min_inc + 7'd1;
        end
        if (min_inc > {1'b0, MIN_MAX}) begin
          min_inc  = 7'd0;
          hour_inc = hour_inc + 6'd1;
        end
        nxt.second = sec_inc[5:0];
        nxt.minute = min_inc[5:0];
        nxt.hour   = hour_inc[4:0];
        if (hour_inc > {1'b0, HOUR_MAX}) begin
          nxt.hour = 5'd0;
          nxt.day  = day_inc[4:0];
          if (day_inc > {1'b0, mlen}) begin
            nxt.day   = 5'd1;
            nxt.month = month_inc[3:0];
            if (month_inc > {1'b0, MONTH_MAX}) begin
              nxt.month = 4'd1;
              if (cur.year >= YEAR_MAX) begin
                nxt.year         = 14'd0;
                nxt.year_rem     = 7'd0;
                nxt.century_mod4 = 2'd0;
              end else begin
                nxt.year = cur.year + 14'd1;
                if (cur.year_rem == YEAR_REM_MAX) begin
                  nxt.year_rem     = 7'd0;
                  nxt.century_mod4 = cur.century_mod4 + 2'd1;
                end else begin
                  nxt.year_rem = cur.year_rem + 7'd1;
                end
              end
            end
          end
        end
      end
    end else begin
      case (field_select)
        SEL_SECOND: nxt.second = bump(cur.second, direction, SEC_MAX);
        SEL_MINUTE: nxt.minute = bump(cur.minute, direction, MIN_MAX);
        SEL_HOUR: begin
          nxt.hour = hour_adj[4:0];
        end
        SEL_DAY: begin
          nxt.day = day_adj[4:0];
        end
        SEL_MONTH: begin
          nxt.month = month_adj[3:0];
        end
        SEL_YEAR: begin
          if (direction == DIR_DOWN) begin
            if (cur.year == 14'd0 || cur.year > YEAR_MAX) begin
              nxt.year         = 14'd0;
              nxt.year_rem     = 7'd0;
              nxt.century_mod4 = 2'd0;
            end else begin
              nxt.year = cur.year - 14'd1;
              if (cur.year_rem == 7'd0) begin
                nxt.year_rem     = YEAR_REM_MAX;
                nxt.century_mod4 = cur.century_mod4 - 2'd1;
              end else begin
                nxt.year_rem = cur.year_rem - 7'd1;
              end
            end
          end else begin
            if (cur.year >= YEAR_MAX) begin
              nxt.year         = 14'd0;
              nxt.year_rem     = 7'd0;
              nxt.century_mod4 = 2'd0;
            end else begin
              nxt.year = cur.year + 14'd1;
              if (cur.year_rem == YEAR_REM_MAX) begin
                nxt.year_rem     = 7'd0;
                nxt.century_mod4 = cur.century_mod4 + 2'd1;
              end else begin
                nxt.year_rem = cur.year_rem + 7'd1;
              end
            end
          end
        end
        default: nxt = cur;
      endcase
    end
  end

endmodule
